>>> sv/oais_pkg.sv
package oais_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed port field widths
    localparam int CMD_W    = 2;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int FIDX_W   = 6;
    localparam int FCNT_W   = 7;

    // Width used when comparing a requested position with the fill count
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FRONT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_AT_POS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISS   = 2'd3;

    // Command handed to the engine
    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } request_t;

    // Result returned by the engine
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  count;
    } result_t;

endpackage

>>> sv/oais_engine.sv
module oais_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  oais_pkg::request_t req,
    output logic               idle,
    output logic               done_valid,
    input  logic               done_ready,
    output oais_pkg::result_t  res
);

    localparam int IDX_W = oais_pkg::IDX_W;
    localparam int CNT_W = oais_pkg::CNT_W;
    localparam int CMP_W = oais_pkg::CMP_W;
    localparam int VAL_W = oais_pkg::VAL_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_WRITE  = 5'b00100,
        S_SEARCH = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        tag_reg, tag_next;       // address of data in flight
    logic                    pend_reg, pend_next;     // read data valid this cycle
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic [oais_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic [IDX_W-1:0]        ridx_reg, ridx_next;

    // Table storage, one write and one registered read per cycle
    logic signed [VAL_W-1:0] mem [oais_pkg::CAPACITY];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    rd_en, wr_en;
    logic [IDX_W-1:0]        rd_addr, wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    logic [CMP_W-1:0]        req_pos_ext, count_ext;
    logic                    is_last, is_match;

    assign req_pos_ext = CMP_W'(req.position);
    assign count_ext   = CMP_W'(count_reg);
    assign is_last     = (CNT_W'(tag_reg) == (count_reg - CNT_W'(1)));
    assign is_match    = (rd_data_reg == value_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        tag_next   = tag_reg;
        pend_next  = 1'b0;
        value_next = value_reg;
        stat_next  = stat_reg;
        ridx_next  = ridx_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = tag_reg;
        wr_data    = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next = req.value;
                    ridx_next  = '0;
                    if (req.command == oais_pkg::CMD_SEARCH)
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next  = oais_pkg::STAT_MISS;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            state_next = S_SEARCH;
                        end
                    end
                    else if (req.command == oais_pkg::CMD_AT_POS && req_pos_ext > count_ext)
                    begin
                        stat_next  = oais_pkg::STAT_BADPOS;
                        state_next = S_DONE;
                    end
                    else if (count_reg == CNT_W'(oais_pkg::CAPACITY))
                    begin
                        stat_next  = oais_pkg::STAT_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        case (req.command)
                            oais_pkg::CMD_FRONT:  pos_next = '0;
                            oais_pkg::CMD_AT_POS: pos_next = IDX_W'(req.position);
                            default:              pos_next = IDX_W'(count_reg);
                        endcase
                        ptr_next   = IDX_W'(count_reg);
                        state_next = S_SHIFT;
                    end
                end
            end

            // Move entries up one slot, top first: read below, write in the following cycle
            S_SHIFT:
            begin
                wr_en = pend_reg;
                if (ptr_reg != pos_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_reg - IDX_W'(1);
                    tag_next  = ptr_reg;
                    pend_next = 1'b1;
                    ptr_next  = ptr_reg - IDX_W'(1);
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = value_reg;
                count_next = count_reg + CNT_W'(1);
                stat_next  = oais_pkg::STAT_OK;
                state_next = S_DONE;
            end

            // Linear scan, compare each entry in the cycle after its read
            S_SEARCH:
            begin
                if (pend_reg && is_match)
                begin
                    stat_next  = oais_pkg::STAT_OK;
                    ridx_next  = tag_reg;
                    state_next = S_DONE;
                end
                else if (pend_reg && is_last)
                begin
                    stat_next  = oais_pkg::STAT_MISS;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_reg;
                    tag_next  = ptr_reg;
                    pend_next = 1'b1;
                    ptr_next  = ptr_reg + IDX_W'(1);
                end
            end

            S_DONE:
            begin
                if (done_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        pos_reg   <= pos_next;
        tag_reg   <= tag_next;
        value_reg <= value_next;
        stat_reg  <= stat_next;
        ridx_reg  <= ridx_next;
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign idle       = (state_reg == S_IDLE);
    assign done_valid = (state_reg == S_DONE);
    assign res.status = stat_reg;
    assign res.index  = ridx_reg;
    assign res.count  = count_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(oais_pkg::CAPACITY))
        else $error("fill count above capacity");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (count_reg < CNT_W'(oais_pkg::CAPACITY)))
        else $error("insert attempted on a full table");

    a_count_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WRITE) |=> $stable(count_reg))
        else $error("fill count changed outside the write step");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && pend_reg) |-> (CNT_W'(tag_reg) < count_reg))
        else $error("search compared an entry beyond the fill count");

endmodule

>>> sv/ordered_array_insert_search.sv
// An insert moves the entries at and above its position up one slot, top first, then
// writes the value. Search compares entries from index 0 up to a match or the last one;
// an empty table is a miss. A rejected insert (bad position or full table) writes nothing.
// Throughput: one command at a time; the table is walked one entry a cycle.
// A result held in the output register does not stop the next command being taken.
// Reset (rst_n low, asynchronous) empties the table; entry contents are left undefined.
module ordered_array_insert_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [oais_pkg::CMD_W-1:0]          command,
    input  logic signed [oais_pkg::VAL_W-1:0]   value,
    input  logic [oais_pkg::POS_W-1:0]          position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [oais_pkg::STAT_W-1:0]         status,
    output logic [oais_pkg::FIDX_W-1:0]         found_index,
    output logic [oais_pkg::FCNT_W-1:0]         fill_count
);

    oais_pkg::request_t req;
    oais_pkg::result_t  res;
    logic               eng_idle, done_valid, done_ready;

    logic                                out_valid_reg;
    logic [oais_pkg::STAT_W-1:0]         status_reg;
    logic [oais_pkg::FIDX_W-1:0]         found_index_reg;
    logic [oais_pkg::FCNT_W-1:0]         fill_count_reg;

    assign req.command  = command;
    assign req.value    = value;
    assign req.position = position;

    // Input side takes a transfer whenever the engine is idle
    assign in_stall   = !eng_idle;
    assign done_ready = !out_valid_reg || !out_stall;

    oais_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && !in_stall),
        .req        (req),
        .idle       (eng_idle),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .res        (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_ready)
        begin
            out_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ready && done_valid)
        begin
            status_reg      <= res.status;
            found_index_reg <= oais_pkg::FIDX_W'(res.index);
            fill_count_reg  <= oais_pkg::FCNT_W'(res.count);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = found_index_reg;
    assign fill_count  = fill_count_reg;

endmodule
